// ----- rtl/core/bmsf_pkg.sv -----
// Shared constants, codes and payload types of the bitmap merge and span fill block.
`default_nettype none

package bmsf_pkg;

    localparam int CANVAS_WIDTH  = 64;
    localparam int CANVAS_HEIGHT = 64;
    localparam int COL_W         = $clog2(CANVAS_WIDTH);
    localparam int ROW_W         = $clog2(CANVAS_HEIGHT);
    localparam int TOP_LIM       = ((CANVAS_HEIGHT < 64) ? CANVAS_HEIGHT : 64) - 1;
    localparam int BOT_LIM       = (CANVAS_HEIGHT < 127) ? CANVAS_HEIGHT : 127;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    typedef logic [CANVAS_WIDTH-1:0] t_row;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] rect_x;
        logic [5:0] rect_y;
        logic [6:0] rect_width;
        logic [6:0] rect_height;
        logic       pixel_bit;
        logic [5:0] row_index;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] row_bits;
        logic [5:0]  box_left;
        logic [5:0]  box_top;
        logic [6:0]  box_right_end;
        logic [6:0]  box_bottom_end;
        logic        box_valid;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/bmsf_in_if.sv -----
// Command channel interface of the bitmap merge and span fill block.
`default_nettype none

interface bmsf_in_if;
    import bmsf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bmsf_out_if.sv -----
// Result channel interface of the bitmap merge and span fill block.
`default_nettype none

interface bmsf_out_if;
    import bmsf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bitmap_merge_and_span_fill_top.sv -----
// Top level of the bitmap merge and span fill block: canvas memory and command sequencer.
// A begin, or a pixel that sets no bit, ends in the idle state; a pixel that sets one passes
// a read and a write state. A read passes a read and a load state for the registered canvas
// read port, then the result transfer; a fill also ends with the result transfer: one shared
// scan step visits one column a cycle, with a read, a load and a write-back for every row.
// Reset is synchronous; it clears the per-row valid flags, so the canvas reads as zero at once.
`default_nettype none

module bitmap_merge_and_span_fill_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bmsf_in_if.sink    i_in,
    bmsf_out_if.source o_out
);
    import bmsf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRD,
        S_PWR,
        S_FRD,
        S_FLOAD,
        S_FSCAN,
        S_FWR,
        S_RRD,
        S_RLOAD,
        S_OUT
    } t_state;

    t_state     r_state;
    t_out_item  r_out;

    logic [5:0] r_bound_left;
    logic [5:0] r_bound_top;
    logic [6:0] r_bound_right;
    logic [6:0] r_bound_bottom;
    logic       r_bound_seen;
    logic [5:0] r_src_x;
    logic [5:0] r_src_y;
    logic [6:0] r_src_cols;
    logic [6:0] r_cur_col;
    logic [6:0] r_cur_row;

    logic [ROW_W-1:0] r_addr;
    logic [COL_W-1:0] r_col;
    logic             r_par;
    logic             r_rd_ok;
    t_row             r_row;

    t_row                    r_mem [CANVAS_HEIGHT];
    logic [CANVAS_HEIGHT-1:0] r_valid;
    t_row                    r_rd_q;
    logic                    r_rd_v;

    logic       in_xfer;
    logic       mem_we;
    t_row       mem_wdata;
    t_row       rd_data;
    logic [7:0] ax;
    logic [7:0] ay;
    logic       pix_active;
    logic       pix_hit;
    logic [6:0] n_cur_col;
    logic [7:0] right_sum;
    logic [7:0] bottom_sum;
    logic [5:0] n_left;
    logic [5:0] n_top;
    logic [6:0] n_right;
    logic [6:0] n_bottom;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = r_out;
    assign in_xfer     = i_in.valid && i_in.ready;

    assign rd_data = r_rd_v ? r_rd_q : '0;

    always_comb begin
        ax         = {2'b00, r_src_x} + {1'b0, r_cur_col};
        ay         = {2'b00, r_src_y} + {1'b0, r_cur_row};
        pix_active = (r_src_cols != 7'd0) && (r_cur_row != 7'd127);
        pix_hit    = pix_active && i_in.data.pixel_bit
                     && (int'(ax) < CANVAS_WIDTH) && (int'(ay) < CANVAS_HEIGHT);
        n_cur_col  = r_cur_col + 7'd1;

        right_sum  = {2'b00, i_in.data.rect_x} + {1'b0, i_in.data.rect_width};
        bottom_sum = {2'b00, i_in.data.rect_y} + {1'b0, i_in.data.rect_height};
        n_left     = (int'(i_in.data.rect_x) > CANVAS_WIDTH - 1)
                     ? 6'(CANVAS_WIDTH - 1) : i_in.data.rect_x;
        n_top      = (int'(i_in.data.rect_y) > TOP_LIM) ? 6'(TOP_LIM) : i_in.data.rect_y;
        n_right    = (int'(right_sum) > CANVAS_WIDTH) ? 7'(CANVAS_WIDTH) : right_sum[6:0];
        n_bottom   = (int'(bottom_sum) > BOT_LIM) ? 7'(BOT_LIM) : bottom_sum[6:0];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_row;
        case (r_state)
            S_PWR: begin
                mem_we    = 1'b1;
                mem_wdata = rd_data | (t_row'(1) << r_col);
            end
            S_FWR: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd_q <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            r_rd_v <= r_valid[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bound_left   <= '0;
            r_bound_top    <= '0;
            r_bound_right  <= '0;
            r_bound_bottom <= '0;
            r_bound_seen   <= 1'b0;
            r_src_x        <= '0;
            r_src_y        <= '0;
            r_src_cols     <= '0;
            r_cur_col      <= '0;
            r_cur_row      <= '0;
            r_addr         <= '0;
            r_col          <= '0;
            r_par          <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_in.data.command)
                            CMD_BEGIN: begin
                                if (!r_bound_seen) begin
                                    r_bound_left   <= n_left;
                                    r_bound_top    <= n_top;
                                    r_bound_right  <= n_right;
                                    r_bound_bottom <= n_bottom;
                                end else begin
                                    if (n_left < r_bound_left) r_bound_left <= n_left;
                                    if (n_top < r_bound_top) r_bound_top <= n_top;
                                    if (n_right > r_bound_right) r_bound_right <= n_right;
                                    if (n_bottom > r_bound_bottom) r_bound_bottom <= n_bottom;
                                end
                                r_bound_seen <= 1'b1;
                                r_src_x      <= i_in.data.rect_x;
                                r_src_y      <= i_in.data.rect_y;
                                r_src_cols   <= i_in.data.rect_width;
                                r_cur_col    <= '0;
                                r_cur_row    <= '0;
                            end
                            CMD_PIXEL: begin
                                if (pix_active) begin
                                    if (n_cur_col >= r_src_cols) begin
                                        r_cur_col <= '0;
                                        r_cur_row <= r_cur_row + 7'd1;
                                    end else begin
                                        r_cur_col <= n_cur_col;
                                    end
                                end
                                if (pix_hit) begin
                                    r_addr  <= ROW_W'(ay);
                                    r_col   <= COL_W'(ax);
                                    r_state <= S_PRD;
                                end
                            end
                            CMD_FILL: begin
                                r_addr  <= '0;
                                r_state <= S_FRD;
                            end
                            default: begin
                                r_addr  <= ROW_W'(i_in.data.row_index);
                                r_rd_ok <= int'(i_in.data.row_index) < CANVAS_HEIGHT;
                                r_state <= S_RRD;
                            end
                        endcase
                    end
                end
                S_PRD: begin
                    r_state <= S_PWR;
                end
                S_PWR: begin
                    r_state <= S_IDLE;
                end
                S_FRD: begin
                    r_state <= S_FLOAD;
                end
                S_FLOAD: begin
                    r_row   <= rd_data;
                    r_col   <= '0;
                    r_par   <= 1'b0;
                    r_state <= S_FSCAN;
                end
                S_FSCAN: begin
                    // A pixel inside an open span is set only if a closing hit lies further on.
                    r_row[r_col] <= r_row[r_col] | (r_par & (|(r_row >> r_col)));
                    r_par        <= r_par ^ r_row[r_col];
                    r_col        <= r_col + 1'b1;
                    if (r_col == COL_W'(CANVAS_WIDTH - 1)) begin
                        r_state <= S_FWR;
                    end
                end
                S_FWR: begin
                    if (r_addr == ROW_W'(CANVAS_HEIGHT - 1)) begin
                        r_out.result_kind    <= KIND_FILL;
                        r_out.row_bits       <= '0;
                        r_out.box_left       <= r_bound_left;
                        r_out.box_top        <= r_bound_top;
                        r_out.box_right_end  <= r_bound_right;
                        r_out.box_bottom_end <= r_bound_bottom;
                        r_out.box_valid      <= r_bound_seen;
                        r_state              <= S_OUT;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_RRD: begin
                    r_state <= S_RLOAD;
                end
                S_RLOAD: begin
                    r_out.result_kind    <= KIND_ROW;
                    r_out.row_bits       <= r_rd_ok ? 64'(rd_data) : 64'd0;
                    r_out.box_left       <= r_bound_left;
                    r_out.box_top        <= r_bound_top;
                    r_out.box_right_end  <= r_bound_right;
                    r_out.box_bottom_end <= r_bound_bottom;
                    r_out.box_valid      <= r_bound_seen;
                    r_state              <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("Command taken while a result is pending.");

    a_fill_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.result_kind == KIND_FILL) |-> (o_out.data.row_bits == 64'd0))
        else $error("Fill result carries row data.");

    a_fill_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.data.command == CMD_FILL) |=> (r_state == S_FRD && r_addr == '0))
        else $error("Fill did not start at the first row.");

    a_scan_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FSCAN && r_col == COL_W'(CANVAS_WIDTH - 1)) |=> (r_state == S_FWR))
        else $error("Row scan did not end at the last column.");

endmodule

`default_nettype wire

// ----- tb/sv/bitmap_merge_and_span_fill_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap merge and span fill block, with its own canvas predictor.
module bitmap_merge_and_span_fill_top_test;
    import bmsf_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int FILL_BUDGET = 30;
    localparam int TAIL_ITEMS  = 150;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        t_in_item item;
        bit       wait_drained;
    } t_cmd_slot;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bmsf_in_if  cmd_if ();
    bmsf_out_if reply_if ();

    bitmap_merge_and_span_fill_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (reply_if)
    );

    t_cmd_slot cmd_backlog[$];
    t_out_item pending_replies[$];

    t_row       canvas_img [CANVAS_HEIGHT];
    logic [5:0] box_l, box_t;
    logic [6:0] box_r, box_b;
    logic       box_seen;
    int         org_x, org_y, span_cols, col_pos, row_pos;

    int total_cmds      = 0;
    int accepted_cnt    = 0;
    int replies_checked = 0;
    int fail_count      = 0;
    int n_begin = 0, n_pixel = 0, n_clipped = 0, n_fill = 0, n_read = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got 0x%0h, want 0x%0h",
                                    replies_checked, name, got, want));
    endtask

    function automatic bit idling_allowed();
        return (accepted_cnt < total_cmds - TAIL_ITEMS) && (((accepted_cnt >> 7) % 4) != 3);
    endfunction

    // A span is committed only when its closing hit is found; a trailing open span is dropped.
    function automatic t_row span_filled(t_row src);
        t_row filled;
        t_row span;
        bit   in_span;
        int   c;
        filled  = src;
        span    = '0;
        in_span = 1'b0;
        for (c = 0; c < CANVAS_WIDTH; c++) begin
            if (src[c]) begin
                if (in_span)
                    filled = filled | span;
                span    = '0;
                in_span = !in_span;
            end else if (in_span) begin
                span[c] = 1'b1;
            end
        end
        return filled;
    endfunction

    function automatic void canvas_reset();
        int r;
        for (r = 0; r < CANVAS_HEIGHT; r++)
            canvas_img[r] = '0;
        box_l = '0; box_t = '0; box_r = '0; box_b = '0; box_seen = 1'b0;
        org_x = 0; org_y = 0; span_cols = 0; col_pos = 0; row_pos = 0;
    endfunction

    // Updates the canvas for one accepted command and queues the result it causes, if any.
    function automatic void apply_command(t_in_item c);
        int        l, t, r, b, ax, ay, row;
        t_out_item rep;
        case (c.command)
            CMD_BEGIN: begin
                n_begin++;
                l = (c.rect_x < CANVAS_WIDTH - 1) ? c.rect_x : CANVAS_WIDTH - 1;
                t = (c.rect_y < TOP_LIM) ? c.rect_y : TOP_LIM;
                r = (c.rect_x + c.rect_width < CANVAS_WIDTH) ? c.rect_x + c.rect_width
                                                             : CANVAS_WIDTH;
                b = (c.rect_y + c.rect_height < BOT_LIM) ? c.rect_y + c.rect_height : BOT_LIM;
                if (!box_seen || l < box_l) box_l = 6'(l);
                if (!box_seen || t < box_t) box_t = 6'(t);
                if (!box_seen || r > box_r) box_r = 7'(r);
                if (!box_seen || b > box_b) box_b = 7'(b);
                box_seen  = 1'b1;
                org_x     = int'(c.rect_x);
                org_y     = int'(c.rect_y);
                span_cols = int'(c.rect_width);
                col_pos   = 0;
                row_pos   = 0;
            end
            CMD_PIXEL: begin
                n_pixel++;
                if (span_cols != 0 && row_pos < 127) begin
                    ax = org_x + col_pos;
                    ay = org_y + row_pos;
                    if (ax < CANVAS_WIDTH && ay < CANVAS_HEIGHT) begin
                        if (c.pixel_bit)
                            canvas_img[ROW_W'(ay)][COL_W'(ax)] = 1'b1;
                    end else begin
                        n_clipped++;
                    end
                    col_pos++;
                    if (col_pos >= span_cols) begin
                        col_pos = 0;
                        row_pos++;
                    end
                end
            end
            default: begin
                if (c.command == CMD_FILL) begin
                    n_fill++;
                    for (row = 0; row < CANVAS_HEIGHT; row++)
                        canvas_img[row] = span_filled(canvas_img[row]);
                    rep.result_kind = KIND_FILL;
                    rep.row_bits    = '0;
                end else begin
                    n_read++;
                    rep.result_kind = KIND_ROW;
                    rep.row_bits    = (c.row_index < CANVAS_HEIGHT) ? canvas_img[c.row_index]
                                                                    : '0;
                end
                rep.box_left       = box_seen ? box_l : '0;
                rep.box_top        = box_seen ? box_t : '0;
                rep.box_right_end  = box_seen ? box_r : '0;
                rep.box_bottom_end = box_seen ? box_b : '0;
                rep.box_valid      = box_seen;
                pending_replies.push_back(rep);
            end
        endcase
    endfunction

    function automatic t_in_item any_cmd(logic [1:0] op);
        t_in_item it;
        it.command     = op;
        it.rect_x      = 6'($urandom_range(0, 63));
        it.rect_y      = 6'($urandom_range(0, 63));
        it.rect_width  = 7'($urandom_range(0, 64));
        it.rect_height = 7'($urandom_range(0, 64));
        it.pixel_bit   = 1'($urandom_range(0, 1));
        it.row_index   = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic t_in_item begin_cmd(int x, int y, int w, int h);
        t_in_item it;
        it             = any_cmd(CMD_BEGIN);
        it.rect_x      = 6'(x);
        it.rect_y      = 6'(y);
        it.rect_width  = 7'(w);
        it.rect_height = 7'(h);
        return it;
    endfunction

    function automatic t_in_item pixel_cmd(bit b);
        t_in_item it;
        it           = any_cmd(CMD_PIXEL);
        it.pixel_bit = b;
        return it;
    endfunction

    function automatic t_in_item read_cmd(int row);
        t_in_item it;
        it           = any_cmd(CMD_READ);
        it.row_index = 6'(row);
        return it;
    endfunction

    function automatic void post(t_in_item it, bit drained = 1'b0);
        t_cmd_slot s;
        s.item         = it;
        s.wait_drained = drained;
        cmd_backlog.push_back(s);
    endfunction

    function automatic int edge_biased();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(56, 63) : $urandom_range(0, 63);
    endfunction

    function automatic void build_stimulus();
        int  seq_no, pick, x, y, w, h, dens, i, row, fills_left;
        bit  drain;
        fills_left = FILL_BUDGET;

        post(read_cmd(0));
        post(pixel_cmd(1'b1));
        post(any_cmd(CMD_FILL));
        post(begin_cmd(62, 63, 3, 2));
        repeat (6) post(pixel_cmd(1'b1));
        post(read_cmd(63));
        post(begin_cmd(63, 0, 0, 0));
        post(begin_cmd(0, 5, 8, 1));
        post(pixel_cmd(1'b1)); post(pixel_cmd(1'b0)); post(pixel_cmd(1'b0));
        post(pixel_cmd(1'b1)); post(pixel_cmd(1'b0)); post(pixel_cmd(1'b1));
        post(pixel_cmd(1'b0)); post(pixel_cmd(1'b0));
        post(read_cmd(5));
        post(any_cmd(CMD_FILL));
        post(read_cmd(5));
        post(read_cmd(63));

        seq_no = 0;
        while (cmd_backlog.size() < ITEM_TARGET) begin
            pick  = $urandom_range(0, 99);
            drain = (seq_no == 20) || ($urandom_range(0, 49) == 0);
            if (seq_no == 40 || pick == 0) begin
                // The cursor runs past row 126, after which pixels are dropped.
                post(begin_cmd(edge_biased(), edge_biased(), 1, $urandom_range(0, 3)), drain);
                repeat (135) post(pixel_cmd($urandom_range(0, 7) == 0));
            end else if (pick < 60) begin
                x = edge_biased();
                y = edge_biased();
                case ($urandom_range(0, 9))
                    0: begin
                        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                        h = (w == 0) ? $urandom_range(0, 8) : 0;
                    end
                    1: begin
                        w = $urandom_range(0, 1) ? 64 : $urandom_range(9, 63);
                        h = 1;
                    end
                    2: begin
                        w = $urandom_range(1, 2);
                        h = $urandom_range(0, 1) ? 64 : $urandom_range(9, 31);
                    end
                    default: begin
                        w = $urandom_range(1, 8);
                        h = $urandom_range(1, 8);
                    end
                endcase
                post(begin_cmd(x, y, w, h), drain);
                dens = $urandom_range(1, 4);
                for (i = 0; i < w * h; i++)
                    post(pixel_cmd($urandom_range(0, 4) < dens));
                repeat ($urandom_range(0, 2)) begin
                    row = y + $urandom_range(0, h);
                    if (row > 63)
                        row = $urandom_range(0, 63);
                    post(read_cmd(row));
                end
            end else if (pick < 75) begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 6);
                post(begin_cmd(edge_biased(), edge_biased(), w, h), drain);
                repeat ($urandom_range(0, 2 * w * h + 3))
                    post(pixel_cmd($urandom_range(0, 1)));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4))
                    post(read_cmd($urandom_range(0, 63)), drain);
            end else if (pick < 95 && fills_left > 0) begin
                fills_left--;
                post(any_cmd(CMD_FILL), drain);
                post(read_cmd($urandom_range(0, 63)));
            end else begin
                post(any_cmd($urandom_range(0, 1) ? CMD_PIXEL : CMD_READ), drain);
            end
            seq_no++;
        end
    endfunction

    always @(posedge i_clk) begin : command_driver
        t_cmd_slot slot;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                apply_command(cmd_if.data);
                accepted_cnt++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() == 0) begin
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog[0].wait_drained && pending_replies.size() != 0) begin
                    cmd_if.valid <= 1'b0;
                end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 16);
                    cmd_if.valid <= 1'b0;
                end else begin
                    slot = cmd_backlog.pop_front();
                    cmd_if.data  <= slot.item;
                    cmd_if.valid <= 1'b1;
                end
            end
        end
    end

    // One long stretch with the result side held off while commands keep being offered.
    always @(posedge i_clk) begin
        if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_out_item got, want;
        if (!i_rst_n) begin
            reply_if.ready <= 1'b0;
        end else begin
            if (reply_if.valid && reply_if.ready) begin
                got = reply_if.data;
                if (pending_replies.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            replies_checked));
                end else begin
                    want = pending_replies.pop_front();
                    check_field("result_kind", got.result_kind, want.result_kind);
                    check_field("row_bits", got.row_bits, want.row_bits);
                    check_field("box_left", got.box_left, want.box_left);
                    check_field("box_top", got.box_top, want.box_top);
                    check_field("box_right_end", got.box_right_end, want.box_right_end);
                    check_field("box_bottom_end", got.box_bottom_end, want.box_bottom_end);
                    check_field("box_valid", got.box_valid, want.box_valid);
                end
                replies_checked++;
            end
            if (hold_left != 0) begin
                reply_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                reply_if.ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                reply_if.ready <= 1'b0;
            end else begin
                reply_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.data    = '0;
        reply_if.ready = 1'b0;
        canvas_reset();
        build_stimulus();
        total_cmds = cmd_backlog.size();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_cnt < total_cmds)
            @(posedge i_clk);
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d commands: %0d begins, %0d pixels (%0d clipped), %0d fills, %0d reads.",
                 accepted_cnt, n_begin, n_pixel, n_clipped,
                 n_fill, n_read);
        $display("Checked %0d results, %0d mismatches.", replies_checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
